// ===== rtl/bfa_pkg.sv =====
package bfa_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_BLOCKS_DEF = 64;
  localparam int FREE_WIDTH_DEF = 32;

  // Allocation granule in bytes, a power of two
  localparam int ALIGN_UNIT   = 8;
  localparam int DEFAULT_BASE = 512;

  // Fixed field widths
  localparam int START_W = 21;
  localparam int REQ_W   = 25;
  localparam int SIZE_W  = REQ_W + 1;
  localparam int BASE_W  = START_W + 1;
  localparam int NUM_W   = 6;
  localparam int OFF_W   = 27;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LAST,
    S_LASTCMP,
    S_FFA,
    S_FFB,
    S_FFC,
    S_FFRET,
    S_NEW,
    S_NEW2,
    S_SKIPA,
    S_SKIPB,
    S_SORT0,
    S_SORT1,
    S_CHR,
    S_CHW,
    S_FIN,
    S_OUT
  } st_t;

  // Which step of the item started the current search
  typedef enum logic [1:0] {
    CALL_FIT,
    CALL_SORT,
    CALL_CHAIN
  } call_t;

  // Round a request up to the granule
  function automatic logic [SIZE_W-1:0] align_req(input logic [REQ_W-1:0] v);
    logic [SIZE_W-1:0] s;
    s = {1'b0, v} + SIZE_W'(ALIGN_UNIT - 1);
    return s & ~SIZE_W'(ALIGN_UNIT - 1);
  endfunction

  // Base block size from the start register
  function automatic logic [BASE_W-1:0] block_base(input logic [START_W-1:0] v);
    logic [BASE_W-1:0] s;
    s = {1'b0, v} + BASE_W'(ALIGN_UNIT - 1);
    if (v == '0) begin
      return BASE_W'(DEFAULT_BASE);
    end
    return s & ~BASE_W'(ALIGN_UNIT - 1);
  endfunction

endpackage

// ===== rtl/bfa_mem.sv =====
module bfa_mem
  import bfa_pkg::*;
#(
  parameter int DEPTH = MAX_BLOCKS_DEF,
  parameter int WIDTH = FREE_WIDTH_DEF + $clog2(MAX_BLOCKS_DEF)
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds its data between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/bfa_ctrl.sv =====
module bfa_ctrl
  import bfa_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int FREE_WIDTH = FREE_WIDTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_wr_en,
  input  logic [START_W-1:0]                       cfg_wr_data,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic [REQ_W-1:0]                         in_request_size,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic                                     out_granted,
  output logic [NUM_W-1:0]                         out_block_number,
  output logic [OFF_W-1:0]                         out_byte_offset,
  output logic                                     out_fresh_block,
  output logic                                     mem_wr_en,
  output logic [$clog2(MAX_BLOCKS)-1:0]            mem_wr_addr,
  output logic [FREE_WIDTH+$clog2(MAX_BLOCKS)-1:0] mem_wr_data,
  output logic                                     mem_rd_en,
  output logic [$clog2(MAX_BLOCKS)-1:0]            mem_rd_addr,
  input  logic [FREE_WIDTH+$clog2(MAX_BLOCKS)-1:0] mem_rd_data
);

  localparam int AW  = $clog2(MAX_BLOCKS);
  localparam int CW  = $clog2(MAX_BLOCKS + 1);
  localparam int FW  = FREE_WIDTH;
  localparam int DW  = $clog2($clog2(MAX_BLOCKS) + 2);
  localparam int NW  = (SIZE_W > FW + 1) ? SIZE_W : FW + 1;
  localparam int BSW = START_W + $clog2(MAX_BLOCKS) + 1;
  localparam int XW0 = (BSW > SIZE_W) ? BSW : SIZE_W;
  localparam int XW  = (XW0 > FW) ? XW0 : FW;
  localparam int YW  = (FW > SIZE_W) ? FW : SIZE_W;
  localparam int TW  = CW + 3;

  st_t               state_r, state_nxt;
  call_t             caller_r, caller_nxt;
  logic [START_W-1:0] start_r;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     fu_r, fu_nxt;
  logic [CW-1:0]     cap_r, cap_nxt;
  logic [DW-1:0]     dbl_r, dbl_nxt;
  logic [FW-1:0]     thr_r, thr_nxt;
  logic [CW-1:0]     lo_r, lo_nxt;
  logic [CW-1:0]     hp1_r, hp1_nxt;
  logic [CW-1:0]     m_r, m_nxt;
  logic [NW-1:0]     need_r, need_nxt;
  logic              ok_r, ok_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [CW-1:0]     i_r, i_nxt;
  logic [FW-1:0]     ifree_r, ifree_nxt;
  logic [AW-1:0]     keep_r, keep_nxt;
  logic [FW-1:0]     cfree_r, cfree_nxt;
  logic [AW-1:0]     cid_r, cid_nxt;
  logic [AW-1:0]     h_r, h_nxt;
  logic [FW-1:0]     tlast_r, tlast_nxt;
  logic              res_gnt_r, res_gnt_nxt;
  logic [AW-1:0]     res_id_r, res_id_nxt;
  logic [FW-1:0]     res_off_r, res_off_nxt;
  logic              res_fresh_r, res_fresh_nxt;
  logic              out_valid_r;
  logic              out_gnt_r;
  logic [NUM_W-1:0]  out_num_r;
  logic [OFF_W-1:0]  out_off_r;
  logic              out_fresh_r;

  logic [FW-1:0]     rd_free;
  logic [AW-1:0]     rd_id;
  logic              fits, size_ok, cap_full, tab_full, sort_go, chain_brk, skip_hit;
  logic              out_load;
  logic [CW-1:0]     m_inc;
  logic [CW:0]       msum;
  logic [CW:0]       cap2;
  logic [CW-1:0]     ncap;
  logic [TW-1:0]     fu3, cap2x;
  logic [BSW-1:0]    bsize;
  logic [XW-1:0]     bmax;
  logic [FW-1:0]     nf_new, nf_hit;

  // Shared conditions of the datapath
  assign rd_free   = mem_rd_data[FW-1:0];
  assign rd_id     = mem_rd_data[FW+AW-1:FW];
  assign fits      = NW'(rd_free) >= need_r;
  assign size_ok   = NW'(size_r) <= NW'(rd_free);
  assign m_inc     = m_r + CW'(1);
  assign msum      = (CW+1)'(lo_r) + (CW+1)'(hp1_r) - (CW+1)'(1);
  assign cap_full  = cnt_r == cap_r;
  assign tab_full  = (cnt_r >= CW'(MAX_BLOCKS)) ||
                     (cap_full && (cap_r >= CW'(MAX_BLOCKS)));
  assign sort_go   = ok_r && (pos_r < i_r);
  assign chain_brk = ((CW'(h_r) + CW'(1)) == i_r) || (rd_free == tlast_r);
  assign skip_hit  = rd_free <= thr_r;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  // Capacity growth and skip-threshold test: fu < 2*cap/3 as 3*fu+3 <= 2*cap
  assign cap2  = {cap_r, 1'b0};
  assign ncap  = (cap_r == '0) ? CW'(1) :
                 ((cap2 > (CW+1)'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : cap2[CW-1:0]);
  assign fu3   = TW'(fu_r) * TW'(3) + TW'(3);
  assign cap2x = TW'(cap_r) << 1;

  // New block size and the free space left in it
  assign bsize  = BSW'(block_base(start_r) >> 1) << dbl_r;
  assign bmax   = (XW'(bsize) < XW'(size_r)) ? XW'(size_r) : XW'(bsize);
  assign nf_new = FW'(bmax - XW'(size_r));
  assign nf_hit = FW'(YW'(rd_free) - YW'(size_r));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_valid) state_nxt = (cnt_r != '0) ? S_LAST : S_NEW;
      S_LAST:    state_nxt = S_LASTCMP;
      S_LASTCMP: state_nxt = size_ok ? S_FFA : S_NEW;
      S_FFA:     state_nxt = S_FFB;
      S_FFB: begin
        if (!fits) begin
          if (hp1_r <= m_inc) begin
            state_nxt = (m_inc < cnt_r) ? S_FFC : S_FFRET;
          end else begin
            state_nxt = S_FFA;
          end
        end else begin
          state_nxt = (m_r <= lo_r) ? S_FFRET : S_FFA;
        end
      end
      S_FFC:     state_nxt = S_FFRET;
      S_FFRET: begin
        case (caller_r)
          CALL_FIT:   state_nxt = ok_r ? S_SORT0 : S_NEW;
          CALL_SORT:  state_nxt = sort_go ? S_CHR : S_OUT;
          CALL_CHAIN: state_nxt = S_CHR;
          default:    state_nxt = S_OUT;
        endcase
      end
      S_NEW:     state_nxt = tab_full ? S_OUT : S_NEW2;
      S_NEW2:    state_nxt = S_SKIPA;
      S_SKIPA:   state_nxt = (fu_r < cnt_r) ? S_SKIPB : S_SORT0;
      S_SKIPB:   state_nxt = skip_hit ? S_SKIPA : S_SORT0;
      S_SORT0:   state_nxt = (i_r == '0) ? S_OUT : S_SORT1;
      S_SORT1:   state_nxt = S_FFA;
      S_CHR:     state_nxt = S_CHW;
      S_CHW:     state_nxt = chain_brk ? S_FIN : S_FFA;
      S_FIN:     state_nxt = S_OUT;
      S_OUT:     if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    caller_nxt    = caller_r;
    size_nxt      = size_r;
    cnt_nxt       = cnt_r;
    fu_nxt        = fu_r;
    cap_nxt       = cap_r;
    dbl_nxt       = dbl_r;
    thr_nxt       = thr_r;
    lo_nxt        = lo_r;
    hp1_nxt       = hp1_r;
    m_nxt         = m_r;
    need_nxt      = need_r;
    ok_nxt        = ok_r;
    pos_nxt       = pos_r;
    i_nxt         = i_r;
    ifree_nxt     = ifree_r;
    keep_nxt      = keep_r;
    cfree_nxt     = cfree_r;
    cid_nxt       = cid_r;
    h_nxt         = h_r;
    tlast_nxt     = tlast_r;
    res_gnt_nxt   = res_gnt_r;
    res_id_nxt    = res_id_r;
    res_off_nxt   = res_off_r;
    res_fresh_nxt = res_fresh_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = '0;
    mem_wr_data   = '0;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) size_nxt = align_req(in_request_size);
      end
      S_LAST: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = AW'(cnt_r - CW'(1));
      end
      S_LASTCMP: begin
        // Largest block fits: search for the best one
        if (size_ok) begin
          need_nxt   = NW'(size_r);
          lo_nxt     = fu_r;
          hp1_nxt    = cnt_r;
          ok_nxt     = 1'b0;
          caller_nxt = CALL_FIT;
        end
      end
      S_FFA: begin
        m_nxt       = msum[CW:1];
        mem_rd_en   = 1'b1;
        mem_rd_addr = AW'(msum[CW:1]);
      end
      S_FFB: begin
        if (!fits) begin
          lo_nxt = m_inc;
          if (hp1_r <= m_inc) begin
            m_nxt = m_inc;
            if (m_inc < cnt_r) begin
              mem_rd_en   = 1'b1;
              mem_rd_addr = AW'(m_inc);
            end
          end
        end else begin
          hp1_nxt = m_r;
          if (m_r <= lo_r) begin
            ok_nxt  = 1'b1;
            pos_nxt = m_r;
          end
        end
      end
      S_FFC: begin
        ok_nxt  = fits;
        pos_nxt = m_r;
      end
      S_FFRET: begin
        case (caller_r)
          CALL_FIT: begin
            // Carve from the top of the found block
            if (ok_r) begin
              mem_wr_en     = 1'b1;
              mem_wr_addr   = AW'(pos_r);
              mem_wr_data   = {rd_id, nf_hit};
              res_gnt_nxt   = 1'b1;
              res_id_nxt    = rd_id;
              res_off_nxt   = nf_hit;
              res_fresh_nxt = 1'b0;
              i_nxt         = pos_r;
              ifree_nxt     = nf_hit;
              keep_nxt      = rd_id;
            end
          end
          CALL_SORT: begin
            if (sort_go) begin
              cfree_nxt = ifree_r;
              cid_nxt   = keep_r;
              h_nxt     = AW'(pos_r);
            end else begin
              mem_wr_en   = 1'b1;
              mem_wr_addr = AW'(i_r);
              mem_wr_data = {keep_r, ifree_r};
            end
          end
          CALL_CHAIN: begin
            h_nxt = ok_r ? AW'(pos_r) : '0;
          end
          default: begin
          end
        endcase
      end
      S_NEW: begin
        if (tab_full) begin
          res_gnt_nxt   = 1'b0;
          res_id_nxt    = '0;
          res_off_nxt   = '0;
          res_fresh_nxt = 1'b0;
        end else if (cap_full) begin
          cap_nxt = ncap;
          dbl_nxt = dbl_r + DW'(1);
          if (fu3 <= cap2x) begin
            thr_nxt = (thr_r != '0) ? (thr_r << 1) : FW'(ALIGN_UNIT);
          end
        end
      end
      S_NEW2: begin
        // Append a block at the end of the table
        mem_wr_en     = 1'b1;
        mem_wr_addr   = AW'(cnt_r);
        mem_wr_data   = {AW'(cnt_r), nf_new};
        res_gnt_nxt   = 1'b1;
        res_id_nxt    = AW'(cnt_r);
        res_off_nxt   = nf_new;
        res_fresh_nxt = 1'b1;
        i_nxt         = cnt_r;
        ifree_nxt     = nf_new;
        keep_nxt      = AW'(cnt_r);
        cnt_nxt       = cnt_r + CW'(1);
      end
      S_SKIPA: begin
        if (fu_r < cnt_r) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = AW'(fu_r);
        end
      end
      S_SKIPB: begin
        if (skip_hit) fu_nxt = fu_r + CW'(1);
      end
      S_SORT0: begin
        if (i_r != '0) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = AW'(i_r - CW'(1));
        end
      end
      S_SORT1: begin
        // Park the left neighbor's space in the entry, then find its new place
        mem_wr_en   = 1'b1;
        mem_wr_addr = AW'(i_r);
        mem_wr_data = {keep_r, rd_free};
        tlast_nxt   = rd_free;
        need_nxt    = NW'(ifree_r) + NW'(1);
        lo_nxt      = fu_r;
        hp1_nxt     = cnt_r;
        ok_nxt      = 1'b0;
        caller_nxt  = CALL_SORT;
      end
      S_CHR: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = h_r;
      end
      S_CHW: begin
        // Drop the carried entry at the run head, pick up the old one
        mem_wr_en   = 1'b1;
        mem_wr_addr = h_r;
        mem_wr_data = {cid_r, cfree_r};
        cfree_nxt   = rd_free;
        cid_nxt     = rd_id;
        if (!chain_brk) begin
          need_nxt   = NW'(rd_free) + NW'(1);
          lo_nxt     = fu_r;
          hp1_nxt    = cnt_r;
          ok_nxt     = 1'b0;
          caller_nxt = CALL_CHAIN;
        end
      end
      S_FIN: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = AW'(i_r);
        mem_wr_data = {cid_r, cfree_r};
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= '0;
      cnt_r       <= '0;
      fu_r        <= '0;
      cap_r       <= '0;
      dbl_r       <= '0;
      thr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) start_r <= cfg_wr_data;
      cnt_r   <= cnt_nxt;
      fu_r    <= fu_nxt;
      cap_r   <= cap_nxt;
      dbl_r   <= dbl_nxt;
      thr_r   <= thr_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    caller_r    <= caller_nxt;
    size_r      <= size_nxt;
    lo_r        <= lo_nxt;
    hp1_r       <= hp1_nxt;
    m_r         <= m_nxt;
    need_r      <= need_nxt;
    ok_r        <= ok_nxt;
    pos_r       <= pos_nxt;
    i_r         <= i_nxt;
    ifree_r     <= ifree_nxt;
    keep_r      <= keep_nxt;
    cfree_r     <= cfree_nxt;
    cid_r       <= cid_nxt;
    h_r         <= h_nxt;
    tlast_r     <= tlast_nxt;
    res_gnt_r   <= res_gnt_nxt;
    res_id_r    <= res_id_nxt;
    res_off_r   <= res_off_nxt;
    res_fresh_r <= res_fresh_nxt;
    if (out_load) begin
      out_gnt_r   <= res_gnt_r;
      out_num_r   <= NUM_W'(res_id_r);
      out_off_r   <= OFF_W'(res_off_r);
      out_fresh_r <= res_fresh_r;
    end
  end

  assign in_stall         = state_r != S_IDLE;
  assign out_valid        = out_valid_r;
  assign out_granted      = out_gnt_r;
  assign out_block_number = out_num_r;
  assign out_byte_offset  = out_off_r;
  assign out_fresh_block  = out_fresh_r;

endmodule

// ===== rtl/best_fit_block_pool_allocator_top.sv =====
// Flow of an accepted beat: the first block is appended directly; else the last block is read
// and, if the request fits, a search finds the best block; else a full table refuses it, or a
// new block is appended and skip checks run. The re-sort then moves entries run by run with a
// search between runs. A search reads one entry per probe and one more after a final miss.
// Throughput: one item at a time; the next beat is taken the cycle after the result loads.
// Reset: synchronous rst_n clears counters, threshold and start size; table memory is not.
module best_fit_block_pool_allocator_top
  import bfa_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int FREE_WIDTH = FREE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [START_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [REQ_W-1:0]   in_request_size,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_granted,
  output logic [NUM_W-1:0]   out_block_number,
  output logic [OFF_W-1:0]   out_byte_offset,
  output logic               out_fresh_block
);

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int MW = FREE_WIDTH + AW;

  logic          mem_wr_en, mem_rd_en;
  logic [AW-1:0] mem_wr_addr, mem_rd_addr;
  logic [MW-1:0] mem_wr_data, mem_rd_data;

  bfa_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .FREE_WIDTH (FREE_WIDTH)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_request_size  (in_request_size),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_granted      (out_granted),
    .out_block_number (out_block_number),
    .out_byte_offset  (out_byte_offset),
    .out_fresh_block  (out_fresh_block),
    .mem_wr_en        (mem_wr_en),
    .mem_wr_addr      (mem_wr_addr),
    .mem_wr_data      (mem_wr_data),
    .mem_rd_en        (mem_rd_en),
    .mem_rd_addr      (mem_rd_addr),
    .mem_rd_data      (mem_rd_data)
  );

  bfa_mem #(
    .DEPTH (MAX_BLOCKS),
    .WIDTH (MW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

// ===== rtl/bfa_chk.sv =====
module bfa_chk
  import bfa_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_granted,
  input logic [NUM_W-1:0]   out_block_number,
  input logic [OFF_W-1:0]   out_byte_offset,
  input logic               out_fresh_block
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // Busy right after an accepted beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat taken while an item is in flight");

  // A refused request carries no placement
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_granted |->
      out_block_number == '0 && out_byte_offset == '0 && !out_fresh_block)
    else $error("refused request reports a placement");

  // A new block only comes with a grant
  a_fresh_gnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fresh_block |-> out_granted)
    else $error("new block reported without grant");

endmodule

bind best_fit_block_pool_allocator_top bfa_chk u_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_granted      (out_granted),
  .out_block_number (out_block_number),
  .out_byte_offset  (out_byte_offset),
  .out_fresh_block  (out_fresh_block)
);

// ===== tb/tb_best_fit_block_pool_allocator_top.sv =====
module tb_best_fit_block_pool_allocator_top;
  import bfa_pkg::*;

  localparam int NBLK = 64;
  localparam longint unsigned FREE_MASK = 64'hFFFF_FFFF;

  typedef struct {
    bit             granted;
    bit [NUM_W-1:0] block_number;
    bit [OFF_W-1:0] byte_offset;
    bit             fresh_block;
  } grant_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [START_W-1:0] cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [REQ_W-1:0]   in_request_size = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_granted;
  logic [NUM_W-1:0]   out_block_number;
  logic [OFF_W-1:0]   out_byte_offset;
  logic               out_fresh_block;

  best_fit_block_pool_allocator_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_request_size  (in_request_size),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_granted      (out_granted),
    .out_block_number (out_block_number),
    .out_byte_offset  (out_byte_offset),
    .out_fresh_block  (out_fresh_block)
  );

  // Allocator shadow state
  longint unsigned pool_free[NBLK];
  int unsigned     pool_id[NBLK];
  int unsigned     pool_count = 0;
  int unsigned     first_open = 0;
  int unsigned     pool_cap = 0;
  int unsigned     doublings = 0;
  longint unsigned skip_level = 0;
  bit [START_W-1:0] start_reg = '0;

  logic [REQ_W-1:0] request_q[$];
  grant_t           grant_q[$];
  int  errors = 0;
  int  req_gap = 0;
  int  resp_gap = 0;
  int  hold_left = 0;
  bit  hold_req = 0;
  bit  idle_on = 1;
  int  n_granted = 0;
  int  n_fresh = 0;
  int  n_refused = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint unsigned rd_free(longint k);
    if (k < 0 || k >= NBLK) return 0;
    return pool_free[k];
  endfunction

  function automatic void move_entry(longint dst, longint src);
    if (dst < NBLK && src < NBLK) begin
      pool_free[dst] = pool_free[src];
      pool_id[dst] = pool_id[src];
    end
  endfunction

  // Leftmost entry from first_open with at least need bytes free, -1 if none
  function automatic longint fit_search(longint unsigned need);
    longint lo, hi, m;
    if (pool_count == 0) return -1;
    lo = first_open;
    hi = longint'(pool_count) - 1;
    forever begin
      m = (lo + hi) / 2;
      if (rd_free(m) < need) begin
        lo = m + 1;
        if (hi < lo) begin
          m++;
          break;
        end
      end else begin
        hi = m - 1;
        if (hi < lo) break;
      end
    end
    if (m < pool_count && rd_free(m) >= need) return m;
    return -1;
  endfunction

  // Open a slot at 'from' by moving one entry per equal-space run up toward 'to'
  function automatic void shift_runs(longint to, longint from);
    longint chain[NBLK+1];
    int     n;
    longint f, r;
    n = 0;
    f = from;
    forever begin
      chain[n] = f;
      n++;
      if (f + 1 == to || rd_free(f) == rd_free(to - 1) || n > NBLK) break;
      r = fit_search(rd_free(f) + 1);
      f = (r < 0) ? 0 : r;
    end
    move_entry(to, chain[n-1]);
    while (n > 1) begin
      move_entry(chain[n-1], chain[n-2]);
      n--;
    end
  endfunction

  function automatic longint unsigned round_up(longint unsigned v);
    return ((v + ALIGN_UNIT - 1) / ALIGN_UNIT) * ALIGN_UNIT;
  endfunction

  function automatic grant_t allocate(logic [REQ_W-1:0] req);
    grant_t          g;
    longint unsigned need, off, base, bsize, ifree;
    longint          pos, r, j;
    int unsigned     served, ncap, keep;
    bit              hit;
    g = '{0, 0, 0, 0};
    need = round_up(longint'(req));
    pos = pool_count;
    hit = 0;
    if (pool_count > 0 && need <= rd_free(longint'(pool_count) - 1)) begin
      r = fit_search(need);
      if (r >= 0) begin
        hit = 1;
        pos = r;
      end
    end
    if (hit) begin
      pool_free[pos] = (pool_free[pos] - need) & FREE_MASK;
      off = pool_free[pos];
      served = pool_id[pos];
      g.fresh_block = 0;
    end else begin
      if (pool_count >= NBLK) return g;
      if (pool_count == pool_cap) begin
        ncap = pool_cap ? pool_cap * 2 : 1;
        if (pool_cap >= NBLK) return g;
        if (ncap > NBLK) ncap = NBLK;
        doublings++;
        if (first_open < (pool_cap * 2) / 3)
          skip_level = skip_level ? (skip_level << 1) & FREE_MASK : ALIGN_UNIT;
        pool_cap = ncap;
      end
      base = start_reg ? round_up(longint'(start_reg)) : DEFAULT_BASE;
      bsize = (base >> 1) << doublings;
      if (bsize < need) bsize = need;
      pos = pool_count;
      pool_free[pos] = (bsize - need) & FREE_MASK;
      pool_id[pos] = pool_count;
      pool_count++;
      while (first_open < pool_count && pool_free[first_open] <= skip_level)
        first_open++;
      off = pool_free[pos];
      served = pool_id[pos];
      g.fresh_block = 1;
    end
    // Move the changed entry down to its sorted place
    if (pos > 0 && pos < NBLK) begin
      ifree = pool_free[pos];
      pool_free[pos] = pool_free[pos-1];
      j = fit_search(ifree + 1);
      if (j >= 0 && j < pos) begin
        keep = pool_id[pos];
        shift_runs(pos, j);
        pool_free[j] = ifree;
        pool_id[j] = keep;
      end else begin
        pool_free[pos] = ifree;
      end
    end
    g.granted = 1;
    g.block_number = served[NUM_W-1:0];
    g.byte_offset = off[OFF_W-1:0];
    return g;
  endfunction

  // Drive request beats, predict each one as it is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      req_gap = 0;
    end else begin
      if (in_valid && !in_stall) grant_q.push_back(allocate(in_request_size));
      if (!in_valid || !in_stall) begin
        if (req_gap > 0) begin
          req_gap--;
          in_valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          if (idle_on && $urandom_range(0, 7) == 0) begin
            req_gap = $urandom_range(1, 14);
            in_valid <= 1'b0;
          end else begin
            in_request_size <= request_q.pop_front();
            in_valid <= 1'b1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Count down the long receiver hold
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left <= 400;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Check result beats and drive receiver stalls
  always @(posedge clk) begin
    grant_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (grant_q.size() == 0) begin
          $display("%0t: unexpected result beat granted=%0d block=%0d offset=%0d fresh=%0d",
                   $time, out_granted, out_block_number, out_byte_offset, out_fresh_block);
          errors++;
        end else begin
          e = grant_q.pop_front();
          if (out_granted !== e.granted || out_block_number !== e.block_number ||
              out_byte_offset !== e.byte_offset || out_fresh_block !== e.fresh_block) begin
            $display("%0t: mismatch exp g=%0d blk=%0d off=%0d fresh=%0d", $time,
                     e.granted, e.block_number, e.byte_offset, e.fresh_block);
            $display("%0t:          got g=%0d blk=%0d off=%0d fresh=%0d", $time,
                     out_granted, out_block_number, out_byte_offset, out_fresh_block);
            errors++;
          end
          if (!e.granted) n_refused++;
          else if (e.fresh_block) n_fresh++;
          else n_granted++;
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
      end else if (resp_gap > 0) begin
        resp_gap--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        resp_gap = $urandom_range(0, 13);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [REQ_W-1:0] pick_request();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return 25'd16777216;
      2:       return REQ_W'($urandom_range(0, 16777216));
      3, 4:    return REQ_W'($urandom_range(0, 65535));
      default: return REQ_W'($urandom_range(0, 2047));
    endcase
  endfunction

  // Wait for the block to drain
  task automatic settle();
    while (request_q.size() > 0 || in_valid || grant_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_start(logic [START_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    start_reg = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [REQ_W-1:0] directed[$];
    foreach (pool_free[k]) begin
      pool_free[k] = 0;
      pool_id[k] = 0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Default start size, field extremes and alignment edges
    write_start(0);
    directed = '{0, 1, 7, 8, 9, 0, 16, 255, 256, 257, 511, 512, 1000, 4096,
                 8, 16777215, 24, 16777216, 3, 0, 100, 2048, 65536, 40, 1};
    foreach (directed[k]) request_q.push_back(directed[k]);
    settle();

    // Smallest start size, with a long receiver hold
    write_start(1);
    hold_req = 1;
    repeat (250) request_q.push_back(pick_request());
    settle();

    write_start(21'd1048576);
    repeat (250) request_q.push_back(pick_request());
    settle();

    write_start(21'd1048575);
    repeat (250) request_q.push_back(pick_request());
    settle();

    // Random start size, then a final stretch without idling
    write_start(START_W'($urandom_range(0, 1048576)));
    repeat (150) request_q.push_back(pick_request());
    while (request_q.size() > 0) @(posedge clk);
    idle_on = 0;
    repeat (100) request_q.push_back(pick_request());
    settle();

    $display("Covered %0d reused-block grants, %0d new blocks, %0d refusals (table full)",
             n_granted, n_fresh, n_refused);
    $display("over five start-size settings including default and extremes");
    if (errors == 0)
      $display("tb_best_fit_block_pool_allocator_top OK");
    else
      $display("tb_best_fit_block_pool_allocator_top NOT OK");
    $finish;
  end

  initial begin
    #(12 * 2000000);
    $display("tb_best_fit_block_pool_allocator_top NOT OK");
    $finish;
  end

endmodule
